### hdl/lz78_bitstream_decoder_macros.svh
// Assertion macros for the LZ78 bit stream decoder.
// Used by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef LZ78_BITSTREAM_DECODER_MACROS_SVH
`define LZ78_BITSTREAM_DECODER_MACROS_SVH

// Check prop on every clock edge outside reset.
`define LZ78D_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that pre in one cycle is followed by post in the next.
`define LZ78D_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);

`endif

### hdl/lz78d_pkg.sv
// Package for the LZ78 bit stream decoder: states, parse phases, codes,
// controller/datapath interface structs and the level limit function.
// No dependencies.
package lz78d_pkg;

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_LITERAL,
        PH_WOW,
        PH_WIDTH,
        PH_INDEX,
        PH_BYTE
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_BOUND_RD,
        ST_BOUND_CHK,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_APPEND,
        ST_PHRASE,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_RESP
    } state_t;

    localparam logic [1:0] STS_TAKEN = 2'd0;
    localparam logic [1:0] STS_BYTE  = 2'd1;
    localparam logic [1:0] STS_EMPTY = 2'd2;
    localparam logic [1:0] STS_ERROR = 2'd3;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_PULL = 1'b1;

    localparam logic [1:0] LVL_64K  = 2'd0;
    localparam logic [1:0] LVL_512K = 2'd1;

    localparam logic [5:0] MAX_WOW   = 6'd32;
    localparam logic [5:0] BYTE_BITS = 6'd8;

    typedef struct packed {
        logic accept;
        logic rd_cap;
        logic bound_rd;
        logic bound_chk;
        logic copy_rd;
        logic copy_wr;
        logic append;
        logic phrase;
        logic move_rd;
        logic move_wr;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic rd_go;
        logic need_copy;
        logic need_phrase;
        logic bnd_bad;
        logic len_zero;
        logic cnt_last;
        logic ph_err;
        logic ph_move;
    } stat_t;

    function automatic logic [30:0] level_limit(input logic [1:0] lvl);
        logic [30:0] lim;
        case (lvl)
            LVL_64K:  lim = 31'h0001_0000;
            LVL_512K: lim = 31'h0008_0000;
            default:  lim = 31'h4000_0000;
        endcase
        return lim;
    endfunction

endpackage

### hdl/lz78_bitstream_decoder.sv
// LZ78 bit stream decoder, top level: controller and datapath.
// Depends on lz78d_pkg, lz78d_ctrl, lz78d_dp and lz78d_ram.
//
// Each transfer either pushes one compressed bit (action 0) or pulls one decoded
// byte (action 1); every transfer yields exactly one result. A pull that delivers
// a byte first reads the history RAM; the bit that ends a literal phrase first
// records the phrase. The bit that ends a copy token reads and checks the phrase
// bound, reads and writes each copied byte in turn, then appends its own byte and
// records the phrase. When the phrase count reaches the level limit, pending
// bytes are moved to the front of the history, one read and one write per byte.
// This order follows from the single read and single write port of the history
// RAM, with a registered read. A result also waits while the previous one is held
// by out_stall. A pending result does not block the next transfer.
module lz78_bitstream_decoder #(
    parameter int HISTORY_DEPTH = 65536,
    parameter int DICT_ENTRIES  = 65536
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [1:0] compression_level,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       action,
    input  logic       stream_bit,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [1:0] status
);
    import lz78d_pkg::*;

    cmd_t  cmd;
    stat_t st;

    lz78d_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .st       (st),
        .cmd      (cmd)
    );

    lz78d_dp #(
        .HISTORY_DEPTH(HISTORY_DEPTH),
        .DICT_ENTRIES (DICT_ENTRIES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .compression_level(compression_level),
        .action           (action),
        .stream_bit       (stream_bit),
        .cmd              (cmd),
        .st               (st),
        .out_byte         (out_byte),
        .status           (status)
    );

endmodule

### hdl/lz78d_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module lz78d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/lz78d_ctrl.sv
// Controller state machine of the LZ78 bit stream decoder.
// Depends on lz78d_pkg and lz78_bitstream_decoder_macros.svh.
`include "lz78_bitstream_decoder_macros.svh"
module lz78d_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  lz78d_pkg::stat_t st,
    output lz78d_pkg::cmd_t  cmd
);
    import lz78d_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (st.rd_go)
                        state_next = ST_RD_WAIT;
                    else if (st.need_copy)
                        state_next = ST_BOUND_RD;
                    else if (st.need_phrase)
                        state_next = ST_PHRASE;
                    else
                        state_next = ST_RESP;
                end
            end
            ST_RD_WAIT:
            begin
                cmd.rd_cap = 1'b1;
                state_next = ST_RESP;
            end
            ST_BOUND_RD:
            begin
                cmd.bound_rd = 1'b1;
                state_next   = ST_BOUND_CHK;
            end
            ST_BOUND_CHK:
            begin
                cmd.bound_chk = 1'b1;
                if (st.bnd_bad)
                    state_next = ST_RESP;
                else if (st.len_zero)
                    state_next = ST_APPEND;
                else
                    state_next = ST_COPY_RD;
            end
            ST_COPY_RD:
            begin
                cmd.copy_rd = 1'b1;
                state_next  = ST_COPY_WR;
            end
            ST_COPY_WR:
            begin
                cmd.copy_wr = 1'b1;
                state_next  = st.cnt_last ? ST_APPEND : ST_COPY_RD;
            end
            ST_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = ST_PHRASE;
            end
            ST_PHRASE:
            begin
                cmd.phrase = 1'b1;
                state_next = (!st.ph_err && st.ph_move) ? ST_MOVE_RD : ST_RESP;
            end
            ST_MOVE_RD:
            begin
                cmd.move_rd = 1'b1;
                state_next  = ST_MOVE_WR;
            end
            ST_MOVE_WR:
            begin
                cmd.move_wr = 1'b1;
                state_next  = st.cnt_last ? ST_RESP : ST_MOVE_RD;
            end
            ST_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    `LZ78D_ASSERT_NEXT(a_accept_starts, (in_valid && !in_stall), (state_reg != ST_IDLE), "accepted transfer did not start work")
    `LZ78D_ASSERT_NEXT(a_resp_holds, (state_reg == ST_RESP && out_valid_reg && out_stall), (state_reg == ST_RESP), "result dropped while output stalled")
    `LZ78D_ASSERT(a_load_from_resp, $rose(out_valid_reg) |-> ($past(state_reg) == ST_RESP), "output loaded outside response state")
    `LZ78D_ASSERT_NEXT(a_copy_ends, (state_reg == ST_COPY_WR && st.cnt_last), (state_reg == ST_APPEND), "copy did not end in append")

endmodule

### hdl/lz78d_dp.sv
// Datapath of the LZ78 bit stream decoder: bit parser, positions, history and
// phrase bound memories, output register. Depends on lz78d_pkg and lz78d_ram.
module lz78d_dp #(
    parameter int HISTORY_DEPTH = 65536,
    parameter int DICT_ENTRIES  = 65536
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [1:0]       compression_level,
    input  logic             action,
    input  logic             stream_bit,
    input  lz78d_pkg::cmd_t  cmd,
    output lz78d_pkg::stat_t st,
    output logic [7:0]       out_byte,
    output logic [1:0]       status
);
    import lz78d_pkg::*;

    localparam int HAW = $clog2(HISTORY_DEPTH);
    localparam int HPW = HAW + 1;
    localparam int DAW = $clog2(DICT_ENTRIES);
    localparam int PCW = DAW + 1;
    localparam int RW  = (HPW > PCW) ? HPW : PCW;
    localparam int BW  = 2 * HPW;
    localparam logic [HPW-1:0] HIST_END  = HPW'(HISTORY_DEPTH);
    localparam logic [HPW:0]   HIST_ENDX = (HPW + 1)'(HISTORY_DEPTH);
    localparam logic [PCW-1:0] DICT_END  = PCW'(DICT_ENTRIES);
    localparam logic [RW-1:0]  RUN_HIST  = RW'(HISTORY_DEPTH);
    localparam logic [RW-1:0]  RUN_DICT  = RW'(DICT_ENTRIES);

    logic [1:0]     level_reg;
    logic           err_reg;
    phase_t         phase_reg;
    logic [RW-1:0]  run_reg;
    logic [31:0]    acc_reg;
    logic [5:0]     fw_reg;
    logic [PCW-1:0] pc_reg;
    logic [HPW-1:0] wp_reg, rp_reg, wb_reg;
    logic [HPW-1:0] src_reg, dst_reg, cnt_reg;
    logic [1:0]     res_code_reg;
    logic [7:0]     res_byte_reg;
    logic [7:0]     out_byte_reg;
    logic [1:0]     status_reg;

    phase_t         ph_next;
    logic [RW-1:0]  run_next;
    logic [31:0]    acc_next;
    logic [5:0]     fw_next;
    logic [31:0]    acc_sh;
    logic           p_err, p_lit_we, p_phrase, p_copy;

    logic           rd_ok;
    logic [7:0]     h_rdata;
    logic           h_we, h_re;
    logic [HAW-1:0] h_waddr, h_raddr;
    logic [7:0]     h_wdata;
    logic [BW-1:0]  b_rdata, b_data;
    logic [HPW-1:0] b_start, b_len;
    logic [HPW:0]   end_dst, end_src;
    logic [PCW-1:0] pc_inc;
    logic           wrap;
    logic [HPW-1:0] keep;

    always_comb
    begin
        ph_next  = phase_reg;
        run_next = run_reg;
        acc_next = acc_reg;
        fw_next  = fw_reg;
        p_err    = 1'b0;
        p_lit_we = 1'b0;
        p_phrase = 1'b0;
        p_copy   = 1'b0;
        acc_sh   = {acc_reg[30:0], stream_bit};
        case (phase_reg)
            PH_PREFIX:
            begin
                if (!stream_bit)
                begin
                    if (run_reg >= RUN_HIST)
                        p_err = 1'b1;
                    else
                        run_next = run_reg + 1'b1;
                end
                else if (run_reg != '0)
                begin
                    ph_next  = PH_LITERAL;
                    acc_next = '0;
                    fw_next  = '0;
                end
                else
                begin
                    ph_next = PH_WOW;
                    fw_next = '0;
                end
            end
            PH_LITERAL:
            begin
                acc_next = {24'd0, acc_sh[7:0]};
                fw_next  = fw_reg + 1'b1;
                if (fw_next == BYTE_BITS)
                begin
                    if (wp_reg >= HIST_END)
                    begin
                        p_err = 1'b1;
                    end
                    else
                    begin
                        p_lit_we = 1'b1;
                        acc_next = '0;
                        fw_next  = '0;
                        run_next = run_reg - 1'b1;
                        if (run_next == '0)
                        begin
                            p_phrase = 1'b1;
                            ph_next  = PH_PREFIX;
                        end
                    end
                end
            end
            PH_WOW:
            begin
                if (stream_bit)
                begin
                    if (fw_reg >= MAX_WOW)
                        p_err = 1'b1;
                    else
                        fw_next = fw_reg + 1'b1;
                end
                else
                begin
                    acc_next = '0;
                    if (fw_reg == '0)
                    begin
                        ph_next  = PH_BYTE;
                        run_next = '0;
                    end
                    else
                    begin
                        ph_next  = PH_WIDTH;
                        run_next = RW'(fw_reg);
                    end
                end
            end
            PH_WIDTH:
            begin
                acc_next = acc_sh;
                run_next = run_reg - 1'b1;
                if (run_next == '0)
                begin
                    if (acc_sh > 32'd32)
                    begin
                        p_err = 1'b1;
                    end
                    else
                    begin
                        run_next = RW'(acc_sh[5:0]);
                        acc_next = '0;
                        ph_next  = PH_INDEX;
                        if (acc_sh == '0)
                        begin
                            ph_next = PH_BYTE;
                            fw_next = '0;
                        end
                    end
                end
            end
            PH_INDEX:
            begin
                acc_next = acc_sh;
                run_next = run_reg - 1'b1;
                if (run_next == '0)
                begin
                    if (acc_sh >= 32'(pc_reg))
                    begin
                        p_err = 1'b1;
                    end
                    else
                    begin
                        run_next = RW'(acc_sh[PCW-1:0]);
                        acc_next = '0;
                        fw_next  = '0;
                        ph_next  = PH_BYTE;
                    end
                end
            end
            PH_BYTE:
            begin
                acc_next = {24'd0, acc_sh[7:0]};
                fw_next  = fw_reg + 1'b1;
                if (fw_next == BYTE_BITS)
                begin
                    p_copy = 1'b1;
                end
            end
            default:
            begin
                ph_next  = PH_PREFIX;
                run_next = '0;
                acc_next = '0;
                fw_next  = '0;
            end
        endcase
        if (p_phrase)
        begin
            run_next = '0;
            acc_next = '0;
            fw_next  = '0;
        end
    end

    assign rd_ok   = (rp_reg < wb_reg) && (rp_reg < HIST_END);
    assign b_data  = (run_reg == '0) ? '0 : b_rdata;
    assign b_start = b_data[BW-1:HPW];
    assign b_len   = b_data[HPW-1:0];
    assign end_dst = {1'b0, wp_reg} + {1'b0, b_len} + 1'b1;
    assign end_src = {1'b0, b_start} + {1'b0, b_len};
    assign pc_inc  = pc_reg + 1'b1;
    assign wrap    = (31'(pc_inc) >= level_limit(level_reg));
    assign keep    = wp_reg - rp_reg;

    always_comb
    begin
        st             = '0;
        st.rd_go       = !err_reg && (action == ACT_PULL) && rd_ok;
        st.need_copy   = !err_reg && (action == ACT_PUSH) && p_copy;
        st.need_phrase = !err_reg && (action == ACT_PUSH) && p_phrase;
        st.bnd_bad     = (run_reg >= RUN_DICT) || (run_reg >= RW'(pc_reg)) ||
                         (end_dst > HIST_ENDX) || (end_src > {1'b0, wp_reg});
        st.len_zero    = (b_len == '0);
        st.cnt_last    = (cnt_reg == HPW'(1));
        st.ph_err      = (pc_reg >= DICT_END);
        st.ph_move     = wrap && (keep != '0);
    end

    always_comb
    begin
        h_re    = cmd.accept || cmd.copy_rd || cmd.move_rd;
        h_raddr = (cmd.copy_rd || cmd.move_rd) ? src_reg[HAW-1:0] : rp_reg[HAW-1:0];
        h_we    = (cmd.accept && !err_reg && (action == ACT_PUSH) && p_lit_we) ||
                  cmd.copy_wr || cmd.append || cmd.move_wr;
        h_waddr = cmd.move_wr ? dst_reg[HAW-1:0] : wp_reg[HAW-1:0];
        if (cmd.copy_wr || cmd.move_wr)
            h_wdata = h_rdata;
        else if (cmd.append)
            h_wdata = acc_reg[7:0];
        else
            h_wdata = acc_sh[7:0];
    end

    lz78d_ram #(
        .WIDTH(8),
        .DEPTH(HISTORY_DEPTH)
    ) u_history (
        .clk  (clk),
        .we   (h_we),
        .waddr(h_waddr),
        .wdata(h_wdata),
        .re   (h_re),
        .raddr(h_raddr),
        .rdata(h_rdata)
    );

    lz78d_ram #(
        .WIDTH(BW),
        .DEPTH(DICT_ENTRIES)
    ) u_bounds (
        .clk  (clk),
        .we   (cmd.phrase && !st.ph_err),
        .waddr(pc_reg[DAW-1:0]),
        .wdata({wb_reg, wp_reg - wb_reg}),
        .re   (cmd.bound_rd),
        .raddr(run_reg[DAW-1:0]),
        .rdata(b_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg    <= LVL_64K;
            err_reg      <= 1'b0;
            phase_reg    <= PH_PREFIX;
            run_reg      <= '0;
            acc_reg      <= '0;
            fw_reg       <= '0;
            pc_reg       <= PCW'(1);
            wp_reg       <= '0;
            rp_reg       <= '0;
            wb_reg       <= '0;
            res_code_reg <= STS_TAKEN;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                level_reg <= compression_level;
            end
            if (cmd.accept && !err_reg)
            begin
                if (action == ACT_PULL)
                begin
                    if (rd_ok)
                    begin
                        rp_reg       <= rp_reg + 1'b1;
                        res_code_reg <= STS_BYTE;
                    end
                    else
                    begin
                        res_code_reg <= STS_EMPTY;
                    end
                end
                else
                begin
                    res_code_reg <= STS_TAKEN;
                    phase_reg    <= ph_next;
                    run_reg      <= run_next;
                    acc_reg      <= acc_next;
                    fw_reg       <= fw_next;
                    if (p_err)
                        err_reg <= 1'b1;
                    if (p_lit_we)
                        wp_reg <= wp_reg + 1'b1;
                end
            end
            if (cmd.bound_chk && st.bnd_bad)
            begin
                err_reg <= 1'b1;
            end
            if (cmd.copy_wr || cmd.append)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (cmd.append)
            begin
                phase_reg <= PH_PREFIX;
                run_reg   <= '0;
                acc_reg   <= '0;
                fw_reg    <= '0;
            end
            if (cmd.phrase)
            begin
                if (st.ph_err)
                begin
                    err_reg <= 1'b1;
                end
                else if (wrap)
                begin
                    pc_reg <= PCW'(1);
                    wp_reg <= keep;
                    wb_reg <= keep;
                    rp_reg <= '0;
                end
                else
                begin
                    pc_reg <= pc_inc;
                    wb_reg <= wp_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.bound_chk)
        begin
            src_reg <= b_start;
            cnt_reg <= b_len;
        end
        if (cmd.phrase)
        begin
            src_reg <= rp_reg;
            dst_reg <= '0;
            cnt_reg <= keep;
        end
        if (cmd.copy_rd || cmd.move_rd)
        begin
            src_reg <= src_reg + 1'b1;
        end
        if (cmd.copy_wr || cmd.move_wr)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (cmd.move_wr)
        begin
            dst_reg <= dst_reg + 1'b1;
        end
        if (cmd.rd_cap)
        begin
            res_byte_reg <= h_rdata;
        end
        if (cmd.load_out)
        begin
            status_reg   <= err_reg ? STS_ERROR : res_code_reg;
            out_byte_reg <= (!err_reg && res_code_reg == STS_BYTE) ? res_byte_reg : 8'd0;
        end
    end

    assign out_byte = out_byte_reg;
    assign status   = status_reg;

endmodule
